[rtl/trpid_pkg.sv]
// ----------------------------------------------------------------------------
// trpid_pkg
// Shared types and constants of the three-axis rate PID controller:
// register indexes, gain set, stage load strobes and output limits.
// ----------------------------------------------------------------------------
package trpid_pkg;

  // Number of axes handled side by side (roll, pitch, yaw)
  localparam int unsigned NumAxes = 3;

  // Widths of the datapath
  localparam int unsigned RateW  = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DriveW = 32;
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_PROP   = 3'd0,
    REG_GAIN_INTEG  = 3'd1,
    REG_GAIN_DERIV  = 3'd2,
    REG_INTEG_UPPER = 3'd3,
    REG_INTEG_LOWER = 3'd4
  } trpid_reg_e;

  // Saturation limits of the drive output
  localparam logic signed [DriveW-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DriveW-1:0] DRIVE_MIN = 32'sh8000_0000;

  // Gain set and integrator limits shared by every lane
  typedef struct packed {
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki;
    logic [GainW-1:0]  kd;
    logic [DriveW-1:0] upper;
    logic [DriveW-1:0] lower;
  } trpid_gains_t;

  // Load strobes of the four pipeline stages
  typedef struct packed {
    logic ld_err;
    logic ld_prod;
    logic ld_integ;
    logic ld_drive;
  } trpid_stage_t;

endpackage

[rtl/trpid_ctrl.sv]
// ----------------------------------------------------------------------------
// trpid_ctrl
// Pipeline control: tracks which of the four stages hold an item and
// issues the load strobes so that bubbles collapse while the output stalls.
// ----------------------------------------------------------------------------
module trpid_ctrl
  import trpid_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output trpid_stage_t stage_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic free1, free2, free3, free4;
  logic ld1, ld2, ld3, ld4;

  // Work out which stages may take a new item, from the output back
  always_comb begin
    free4 = !v4_q || !out_stall_i;
    ld4   = v3_q && free4;
    free3 = !v3_q || ld4;
    ld3   = v2_q && free3;
    free2 = !v2_q || ld3;
    ld2   = v1_q && free2;
    free1 = !v1_q || ld2;
    ld1   = in_valid_i && free1;
  end

  // Advance occupancy of each stage
  always_comb begin
    v1_d = ld1 || (v1_q && !ld2);
    v2_d = ld2 || (v2_q && !ld3);
    v3_d = ld3 || (v3_q && !ld4);
    v4_d = ld4 || (v4_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  assign in_stall_o       = !free1;
  assign out_valid_o      = v4_q;
  assign stage_o.ld_err   = ld1;
  assign stage_o.ld_prod  = ld2;
  assign stage_o.ld_integ = ld3;
  assign stage_o.ld_drive = ld4;

endmodule

[rtl/trpid_lane.sv]
// ----------------------------------------------------------------------------
// trpid_lane
// One axis of the controller: error, gain products, clamped integrator,
// previous-error store and the saturated sum, in four register stages.
// ----------------------------------------------------------------------------
module trpid_lane
  import trpid_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  trpid_stage_t       stage_i,
  input  trpid_gains_t       gains_i,
  input  logic [RateW-1:0]   target_i,
  input  logic [RateW-1:0]   measured_i,
  output logic [DriveW-1:0]  drive_o
);

  logic signed [GainW-1:0]  kp, ki, kd;
  logic signed [DriveW-1:0] upper, lower;

  logic signed [16:0] err_d, err_q, prev_q;
  logic signed [17:0] diff;
  logic signed [32:0] prod_p, prod_i;
  logic signed [33:0] prod_d;
  logic signed [24:0] p2_q, i2_q, p3_q;
  logic signed [25:0] d2_q, d3_q;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_d, acc_q;
  logic signed [33:0] total;
  logic [DriveW-1:0]  drive_d, drive_q;

  assign kp    = $signed(gains_i.kp);
  assign ki    = $signed(gains_i.ki);
  assign kd    = $signed(gains_i.kd);
  assign upper = $signed(gains_i.upper);
  assign lower = $signed(gains_i.lower);

  // Stage 1: exact 17-bit error
  assign err_d = 17'($signed(target_i)) - 17'($signed(measured_i));

  always_ff @(posedge clk_i) begin
    if (stage_i.ld_err) begin
      err_q <= err_d;
    end
  end

  // Stage 2: gain products; dropping the low byte floors toward minus infinity
  always_comb begin
    diff   = 18'(prev_q) - 18'(err_q);
    prod_p = 33'(err_q) * 33'(kp);
    prod_i = 33'(err_q) * 33'(ki);
    prod_d = 34'(diff) * 34'(kd);
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.ld_prod) begin
      p2_q <= prod_p[32:8];
      i2_q <= prod_i[32:8];
      d2_q <= prod_d[33:8];
    end
  end

  // Previous error follows the item that leaves stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (stage_i.ld_prod) begin
      prev_q <= err_q;
    end
  end

  // Stage 3: integrate, clamp against the upper limit first, then the lower
  always_comb begin
    acc_sum = 33'(acc_q) + 33'(i2_q);
    if (acc_sum > 33'(upper)) begin
      acc_d = upper;
    end else if (acc_sum < 33'(lower)) begin
      acc_d = lower;
    end else begin
      acc_d = acc_sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (stage_i.ld_integ) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.ld_integ) begin
      p3_q <= p2_q;
      d3_q <= d2_q;
    end
  end

  // Stage 4: sum and saturate; acc_q still holds this item's integral here,
  // as the next item enters stage 3 on the same edge
  always_comb begin
    total = 34'(p3_q) + 34'(acc_q) + 34'(d3_q);
    if (total > 34'(DRIVE_MAX)) begin
      drive_d = DRIVE_MAX;
    end else if (total < 34'(DRIVE_MIN)) begin
      drive_d = DRIVE_MIN;
    end else begin
      drive_d = total[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.ld_drive) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

[rtl/three_axis_rate_pid.sv]
// ----------------------------------------------------------------------------
// three_axis_rate_pid
// Rate PID controller for roll, pitch and yaw with a clamped integrator.
//
// Input channel (in_valid_i / in_stall_o) carries target and measured rate
// for all three axes; output channel (out_valid_o / out_stall_i) returns one
// item of three saturated drive values for every input item, in order.
// Gains and integrator limits are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while no item is in flight, a rule for the user that the block
// does not enforce; unknown indexes are ignored. Each axis has its own
// four-stage lane; the lanes share one gain set and their results are merged
// into one output item. The four register stages, the first loaded on the
// accepting edge, lead to out_valid_o. Throughput is one item per cycle
// while out_stall_i is low, set by the integrator loop (one add and clamp
// per cycle). While the receiver stalls, the result holds on the outputs
// and the pipeline keeps accepting items until all four stages are full.
// Reset zeroes the valid flags, gain set, integrators and previous errors.
// ----------------------------------------------------------------------------
module three_axis_rate_pid
  import trpid_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [RateW-1:0]    target_roll_i,
  input  logic [RateW-1:0]    target_pitch_i,
  input  logic [RateW-1:0]    target_yaw_i,
  input  logic [RateW-1:0]    measured_roll_i,
  input  logic [RateW-1:0]    measured_pitch_i,
  input  logic [RateW-1:0]    measured_yaw_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DriveW-1:0]   drive_roll_o,
  output logic [DriveW-1:0]   drive_pitch_o,
  output logic [DriveW-1:0]   drive_yaw_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [DriveW-1:0]   cfg_data_i
);

  trpid_gains_t gains_q;
  trpid_stage_t stage;

  logic [RateW-1:0]  target   [NumAxes];
  logic [RateW-1:0]  measured [NumAxes];
  logic [DriveW-1:0] drive    [NumAxes];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (cfg_we_i) begin
      unique case (trpid_reg_e'(cfg_idx_i))
        REG_GAIN_PROP:   gains_q.kp    <= cfg_data_i[GainW-1:0];
        REG_GAIN_INTEG:  gains_q.ki    <= cfg_data_i[GainW-1:0];
        REG_GAIN_DERIV:  gains_q.kd    <= cfg_data_i[GainW-1:0];
        REG_INTEG_UPPER: gains_q.upper <= cfg_data_i;
        REG_INTEG_LOWER: gains_q.lower <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Spread the input fields over the lanes
  assign target[0]   = target_roll_i;
  assign target[1]   = target_pitch_i;
  assign target[2]   = target_yaw_i;
  assign measured[0] = measured_roll_i;
  assign measured[1] = measured_pitch_i;
  assign measured[2] = measured_yaw_i;

  trpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stage_o     (stage)
  );

  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    trpid_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .stage_i    (stage),
      .gains_i    (gains_q),
      .target_i   (target[a]),
      .measured_i (measured[a]),
      .drive_o    (drive[a])
    );
  end

  // Merge the lane results into one output item
  assign drive_roll_o  = drive[0];
  assign drive_pitch_o = drive[1];
  assign drive_yaw_o   = drive[2];

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for three_axis_rate_pid. A predictor class tracks
// the gain set, the integrators and the previous errors of all three axes,
// and works out the drive values of every accepted item. Each accepted drive
// item is compared per axis with the oldest prediction. A short directed part
// covers the field extremes, an inverted clamp pair, ignored register
// indexes and output saturation. Random phases with fresh gains follow, two
// of them with a sustained error that winds the integrators up to the rails.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top
  import trpid_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [NumAxes-1:0][RateW-1:0]  rate_set_t;
  typedef logic [NumAxes-1:0][DriveW-1:0] drive_set_t;

  localparam logic [RateW-1:0]  RATE_MAX   = 16'h7FFF;
  localparam logic [RateW-1:0]  RATE_MIN   = 16'h8000;
  localparam logic [DriveW-1:0] GAIN_MAX   = 32'h0000_7FFF;
  localparam logic [DriveW-1:0] GAIN_MIN   = 32'h0000_8000;
  localparam int unsigned       ItemTarget = 1900;
  localparam int unsigned       QuietLimit = 400;

  // --------------------------------------------------------------------------
  // Drive predictor: gain set, integrators, previous errors, expected items
  // --------------------------------------------------------------------------
  class pid_drive_predictor;
    logic signed [GainW-1:0]  kp, ki, kd;
    logic signed [DriveW-1:0] upper, lower;
    longint                   integ [NumAxes];
    longint                   prev_err [NumAxes];
    drive_set_t               drive_q [$];
    int unsigned              errors;
    string                    axis_name [NumAxes] = '{"roll", "pitch", "yaw"};

    function new();
      kp = '0;
      ki = '0;
      kd = '0;
      upper = '0;
      lower = '0;
      errors = 0;
      foreach (integ[a]) begin
        integ[a] = 0;
        prev_err[a] = 0;
      end
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction

    // Apply a register write; unknown indexes leave everything as it is
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DriveW-1:0] data);
      case (idx)
        REG_GAIN_PROP:   kp = data[GainW-1:0];
        REG_GAIN_INTEG:  ki = data[GainW-1:0];
        REG_GAIN_DERIV:  kd = data[GainW-1:0];
        REG_INTEG_UPPER: upper = data;
        REG_INTEG_LOWER: lower = data;
        default: ;
      endcase
    endfunction

    // Advance every axis by one sample and queue the drive item it yields
    function void take_sample(rate_set_t target, rate_set_t measured);
      drive_set_t drive;
      longint     err, p_term, d_term, sum;
      for (int a = 0; a < NumAxes; a++) begin
        err = longint'($signed(target[a])) - longint'($signed(measured[a]));
        p_term = (err * longint'(kp)) >>> 8;
        integ[a] = integ[a] + ((err * longint'(ki)) >>> 8);
        // upper test comes first; with an inverted pair it wins for any value above upper
        if (integ[a] > longint'(upper)) begin
          integ[a] = longint'(upper);
        end else if (integ[a] < longint'(lower)) begin
          integ[a] = longint'(lower);
        end
        d_term = ((prev_err[a] - err) * longint'(kd)) >>> 8;
        sum = p_term + integ[a] + d_term;
        if (sum > longint'(DRIVE_MAX)) begin
          sum = longint'(DRIVE_MAX);
        end else if (sum < longint'(DRIVE_MIN)) begin
          sum = longint'(DRIVE_MIN);
        end
        drive[a] = sum[DriveW-1:0];
        prev_err[a] = err;
      end
      drive_q.push_back(drive);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one accepted drive item with the oldest prediction
    task check_drive(drive_set_t got);
      drive_set_t want;
      if (drive_q.size() == 0) begin
        report($sformatf("drive item %h with nothing outstanding", got));
        return;
      end
      want = drive_q.pop_front();
      for (int a = 0; a < NumAxes; a++) begin
        if (got[a] !== want[a]) begin
          report($sformatf("%s drive %0d, predicted %0d", axis_name[a],
                           $signed(got[a]), $signed(want[a])));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  rate_set_t            target_s    = '0;
  rate_set_t            measured_s  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  wire  [NumAxes-1:0][DriveW-1:0] drive_w;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [DriveW-1:0]    cfg_data_i  = '0;

  pid_drive_predictor   sb;
  bit                   in_idle_en  = 1'b1;
  bit                   out_idle_en = 1'b1;
  int unsigned          items_sent  = 0;
  int unsigned          quiet_cycles = 0;

  three_axis_rate_pid uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_roll_i    (target_s[0]),
    .target_pitch_i   (target_s[1]),
    .target_yaw_i     (target_s[2]),
    .measured_roll_i  (measured_s[0]),
    .measured_pitch_i (measured_s[1]),
    .measured_yaw_i   (measured_s[2]),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_roll_o     (drive_w[0]),
    .drive_pitch_o    (drive_w[1]),
    .drive_yaw_o      (drive_w[2]),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check accepted drive items; end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_drive(drive_w);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before each item
  initial begin : drive_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = out_idle_en ? $urandom_range(0, 10) : 0;
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic rate_set_t trio(input logic [RateW-1:0] r, p, y);
    return {y, p, r};
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_rates(input rate_set_t tg, input rate_set_t ms);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_s   <= tg;
    measured_s <= ms;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_sample(tg, ms);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted item has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DriveW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  // Write the whole gain set, optionally followed by a write to an unused index
  task automatic load_config(input logic [DriveW-1:0] kp, ki, kd, up, lo, input bit stray);
    logic [CfgIdxW-1:0] stray_idx;
    write_reg(REG_GAIN_PROP, kp);
    write_reg(REG_GAIN_INTEG, ki);
    write_reg(REG_GAIN_DERIV, kd);
    write_reg(REG_INTEG_UPPER, up);
    write_reg(REG_INTEG_LOWER, lo);
    if (stray) begin
      stray_idx = REG_INTEG_LOWER + CfgIdxW'($urandom_range(1, 3));
      write_reg(stray_idx, $urandom());
    end
    cfg_we_i <= 1'b0;
  endtask

  // Gain with random upper bits, which the block must ignore
  function automatic logic [DriveW-1:0] rand_gain();
    logic [GainW-1:0] g;
    case ($urandom_range(0, 5))
      0: g = '0;
      1: g = GAIN_MAX[GainW-1:0];
      2: g = GAIN_MIN[GainW-1:0];
      3, 4: g = GainW'($urandom_range(0, 2047)) - GainW'(1024);
      default: g = GainW'($urandom());
    endcase
    return {16'($urandom()), g};
  endfunction

  // Random rates; a bias holds the error large and of one sign
  task automatic rand_rates(output rate_set_t tg, output rate_set_t ms,
                            input int unsigned bias);
    logic [RateW-1:0] hi, lo;
    for (int a = 0; a < NumAxes; a++) begin
      hi = RateW'($urandom_range('h4000, 'h7FFF));
      lo = RateW'($urandom_range(0, 'h4000)) + RATE_MIN;
      if (bias == 1) begin
        tg[a] = hi;
        ms[a] = lo;
      end else if (bias == 2) begin
        tg[a] = lo;
        ms[a] = hi;
      end else begin
        case ($urandom_range(0, 9))
          5, 6, 7: begin
            tg[a] = RateW'($urandom());
            ms[a] = tg[a] + RateW'($urandom_range(0, 64)) - RateW'(32);
          end
          8: begin
            tg[a] = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
            ms[a] = $urandom_range(0, 1) ? RATE_MAX : RATE_MIN;
          end
          9: begin
            tg[a] = RateW'($urandom());
            ms[a] = tg[a];
          end
          default: begin
            tg[a] = RateW'($urandom());
            ms[a] = RateW'($urandom());
          end
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned       phase;
    int unsigned       span;
    int unsigned       bias;
    logic [DriveW-1:0] up, lo;
    rate_set_t         tg, ms;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset gains: everything must come out as zero
    send_rates(trio(RATE_MAX, RATE_MIN, 16'h0000), trio(RATE_MIN, RATE_MAX, 16'h0000));
    send_rates(trio(RATE_MIN, RATE_MAX, 16'hFFFF), trio(RATE_MAX, RATE_MIN, 16'h0001));
    settle();

    // Moderate gains with a negative derivative gain, plus an ignored index
    load_config(32'h0000_0100, 32'h0000_0080, 32'h0000_FF00, 32'd1000, -32'sd1000, 1'b1);
    send_rates(trio(16'h0000, 16'h0000, 16'h0000), trio(16'h0000, 16'h0000, 16'h0000));
    send_rates(trio(RATE_MAX, RATE_MIN, 16'h1234), trio(RATE_MIN, RATE_MAX, 16'h1234));
    send_rates(trio(RATE_MIN, RATE_MAX, 16'h0000), trio(RATE_MAX, RATE_MIN, 16'h0000));
    send_rates(trio(16'd100, -16'sd100, 16'd5), trio(16'h0000, 16'h0000, 16'd5));
    settle();

    // Extreme gains and full-range clamps; swing the error rail to rail
    load_config(GAIN_MAX, GAIN_MAX, GAIN_MIN, DRIVE_MAX, DRIVE_MIN, 1'b0);
    repeat (2) begin
      send_rates(trio(RATE_MAX, RATE_MAX, RATE_MAX), trio(RATE_MIN, RATE_MIN, RATE_MIN));
      send_rates(trio(RATE_MIN, RATE_MIN, RATE_MIN), trio(RATE_MAX, RATE_MAX, RATE_MAX));
    end
    settle();

    // Most negative gains everywhere
    load_config(GAIN_MIN, GAIN_MIN, GAIN_MIN, DRIVE_MAX, DRIVE_MIN, 1'b0);
    send_rates(trio(RATE_MAX, RATE_MIN, RATE_MAX), trio(RATE_MIN, RATE_MAX, RATE_MAX));
    send_rates(trio(RATE_MIN, RATE_MAX, RATE_MIN), trio(RATE_MAX, RATE_MIN, RATE_MAX));
    settle();

    // Upper clamp below the lower one: the upper test takes precedence
    load_config(32'h0000_0000, 32'h0000_0100, 32'h0000_0000, -32'sd100, 32'd100, 1'b1);
    send_rates(trio(16'd50, 16'd50, 16'd50), trio(16'h0000, 16'h0000, 16'h0000));
    send_rates(trio(16'h0000, 16'h0000, 16'h0000), trio(16'd500, 16'd500, 16'd500));
    send_rates(trio(16'd1000, 16'h0000, 16'd3), trio(16'h0000, 16'd1000, 16'd3));
    send_rates(trio(16'h0000, 16'h0000, 16'h0000), trio(16'h0000, 16'h0000, 16'h0000));
    settle();

    // Random phases: fresh gains and limits each time, two wind-up runs
    phase = 0;
    while (items_sent < ItemTarget) begin
      bias = (phase == 2) ? 1 : (phase == 5) ? 2 : 0;
      in_idle_en  = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      out_idle_en = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (bias != 0) begin
        load_config(GAIN_MAX, GAIN_MAX, rand_gain(), DRIVE_MAX, DRIVE_MIN, 1'b0);
        span = 450;
      end else begin
        case ($urandom_range(0, 4))
          0: begin
            up = DRIVE_MAX;
            lo = DRIVE_MIN;
          end
          1: begin
            up = DriveW'($urandom_range(0, 1 << 20));
            lo = -DriveW'($urandom_range(0, 1 << 20));
          end
          2: begin
            up = $urandom();
            lo = $urandom();
          end
          3: begin
            up = $urandom();
            lo = up;
          end
          default: begin
            up = DriveW'($urandom_range(0, 2000)) - DriveW'(1000);
            lo = DriveW'($urandom_range(0, 2000)) - DriveW'(1000);
          end
        endcase
        load_config(rand_gain(), rand_gain(), rand_gain(), up, lo,
                    $urandom_range(0, 3) == 0);
        span = $urandom_range(60, 200);
      end
      repeat (span) begin
        rand_rates(tg, ms, bias);
        send_rates(tg, ms);
      end
      settle();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[three_axis_rate_pid.f]
rtl/trpid_pkg.sv
rtl/trpid_ctrl.sv
rtl/trpid_lane.sv
rtl/three_axis_rate_pid.sv
test/tb_top.sv
